// ===== rtl/core/csam_pkg.sv =====
// Shared types and constants for the contrast-stretch character mapper.
// Holds register indexes, reset values and the controller/datapath link types.
// No dependencies.
`default_nettype none

package csam_pkg;

  localparam int PixW   = 8;
  localparam int CountW = 5;
  localparam int LevelW = 4;
  localparam int CharW  = 8;
  localparam int WordW  = 32;
  localparam int CfgIdxW = 3;
  localparam int DivSteps = PixW;
  localparam int StepW  = $clog2(DivSteps);

  localparam logic [CfgIdxW-1:0] REG_STRETCH_MODE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CHAR_COUNT   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CHARS_0_3    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CHARS_4_7    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CHARS_8_11   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_CHARS_12_15  = 3'd5;

  localparam logic [CountW-1:0] COUNT_RESET = 5'd8;
  localparam logic [CountW-1:0] COUNT_MAX   = 5'd16;
  localparam logic [WordW-1:0]  CHARS_0_3_RESET = 32'h2B2A2340;
  localparam logic [WordW-1:0]  CHARS_4_7_RESET = 32'h202E3A2D;
  localparam logic [PixW-1:0]   MIN_RESET = 8'hFF;
  localparam logic [PixW-1:0]   MAX_RESET = 8'h00;

  typedef struct packed {
    logic scan_upd;
    logic map_load;
    logic div_step;
    logic out_load;
  } csam_cmd_t;

  typedef struct packed {
    logic need_div;
  } csam_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/contrast_stretch_ascii_mapper_unit.sv =====
// Top level of the contrast-stretch character mapper.
// Joins csam_ctrl and csam_dp; uses csam_pkg.
// A scan item gives no result and leaves the unit ready; a new item may follow at once.
// A map item with stretch on and a non-flat range runs the eight divider steps, then S_OUT;
// otherwise it goes to S_OUT at once. S_OUT waits for a free output, then takes the next item.
// Reset is synchronous and active low; it restores the register defaults and range.
`default_nettype none

module contrast_stretch_ascii_mapper_unit
  import csam_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,  // [7:0] pixel
  input  wire logic [1:0]         in_tuser,  // [0] operation, [1] frame_first
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [15:0]             out_tdata, // [7:0] character, [11:8] level, [15:12] zero
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [WordW-1:0]   cfg_wdata
);

  csam_cmd_t         cmd;
  csam_stat_t        stat;
  logic [CharW-1:0]  out_char;
  logic [LevelW-1:0] out_level;

  csam_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  csam_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_pixel  (in_tdata),
    .in_first  (in_tuser[1]),
    .cmd       (cmd),
    .stat      (stat),
    .out_char  (out_char),
    .out_level (out_level)
  );

  assign out_tdata = {4'b0000, out_level, out_char};

endmodule

`default_nettype wire

// ===== rtl/core/csam_ctrl.sv =====
// Controller state machine for the contrast-stretch character mapper.
// Sequences item intake, divider steps and the output register; uses csam_pkg.
`default_nettype none

module csam_ctrl
  import csam_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic       in_op,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  input  wire csam_stat_t stat,
  output csam_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic             valid_r, valid_nxt;
  logic             accept;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = valid_r;
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd.scan_upd = accept && !in_op;
    cmd.map_load = accept && in_op;
    cmd.div_step = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_op) begin
          step_nxt  = '0;
          state_nxt = stat.need_div ? S_DIV : S_OUT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == StepW'(DivSteps - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/csam_dp.sv =====
// Datapath for the contrast-stretch character mapper: configuration registers,
// frame range tracking, restoring divider and table lookup; uses csam_pkg.
`default_nettype none

module csam_dp
  import csam_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [WordW-1:0]   cfg_wdata,
  input  wire logic [PixW-1:0]    in_pixel,
  input  wire logic               in_first,
  input  wire csam_cmd_t          cmd,
  output csam_stat_t              stat,
  output logic [CharW-1:0]        out_char,
  output logic [LevelW-1:0]       out_level
);

  logic                  mode_r;
  logic [CountW-1:0]     count_r;
  logic [4*WordW-1:0]    chars_r;
  logic [PixW-1:0]       min_r, max_r;
  logic [PixW-1:0]       rem_r, rem_nxt;
  logic [PixW-1:0]       quo_r, quo_nxt;
  logic [PixW-1:0]       den_r;
  logic [CharW-1:0]      char_r;
  logic [LevelW-1:0]     level_r;

  logic [PixW-1:0]       clamped, diff, range;
  logic [2*PixW-1:0]     num;
  logic [PixW:0]         trial;
  logic [CountW-1:0]     count_sat;
  logic [PixW+CountW-1:0] prod;
  logic [LevelW-1:0]     idx;

  assign range         = max_r - min_r;
  assign stat.need_div = mode_r && (max_r > min_r);

  always_comb begin
    clamped = in_pixel;
    if (in_pixel < min_r) begin
      clamped = min_r;
    end
    if (in_pixel > max_r) begin
      clamped = max_r;
    end
  end

  assign diff  = clamped - min_r;
  assign num   = {diff, {PixW{1'b0}}} - {{PixW{1'b0}}, diff};
  assign trial = {rem_r, quo_r[PixW-1]};

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (cmd.map_load) begin
      if (stat.need_div) begin
        rem_nxt = num[2*PixW-1:PixW];
        quo_nxt = num[PixW-1:0];
      end else begin
        rem_nxt = '0;
        quo_nxt = mode_r ? '0 : in_pixel;
      end
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = PixW'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[PixW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[PixW-1:0];
        quo_nxt = {quo_r[PixW-2:0], 1'b0};
      end
    end
  end

  assign count_sat = (count_r > COUNT_MAX) ? COUNT_MAX : count_r;
  assign prod      = quo_r * count_sat;
  assign idx       = prod[PixW+LevelW-1:PixW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      count_r <= COUNT_RESET;
      chars_r <= {{2*WordW{1'b0}}, CHARS_4_7_RESET, CHARS_0_3_RESET};
      min_r   <= MIN_RESET;
      max_r   <= MAX_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_STRETCH_MODE: mode_r                <= cfg_wdata[0];
          REG_CHAR_COUNT:   count_r               <= cfg_wdata[CountW-1:0];
          REG_CHARS_0_3:    chars_r[WordW-1:0]    <= cfg_wdata;
          REG_CHARS_4_7:    chars_r[2*WordW-1:WordW]   <= cfg_wdata;
          REG_CHARS_8_11:   chars_r[3*WordW-1:2*WordW] <= cfg_wdata;
          REG_CHARS_12_15:  chars_r[4*WordW-1:3*WordW] <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.scan_upd) begin
        if (in_first) begin
          min_r <= in_pixel;
          max_r <= in_pixel;
        end else begin
          if (in_pixel < min_r) begin
            min_r <= in_pixel;
          end
          if (in_pixel > max_r) begin
            max_r <= in_pixel;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (cmd.map_load) begin
      den_r <= range;
    end
    if (cmd.out_load) begin
      level_r <= idx;
      char_r  <= chars_r[idx*CharW +: CharW];
    end
  end

  assign out_char  = char_r;
  assign out_level = level_r;

endmodule

`default_nettype wire
